FILE: hw/rtl/tis_pkg.sv
// Shared types, widths, codes and reset values of the thread interactivity scorer.
`default_nettype none

package tis_pkg;

   // Field widths
   localparam int ACTION_W    = 2;
   localparam int IDX_W       = 6;
   localparam int CLASS_W     = 2;
   localparam int SLEPT_W     = 16;
   localparam int CNT_W       = 24;
   localparam int TOTAL_W     = CNT_W + 1;
   localparam int SCORE_W     = 9;
   localparam int SLICE_W     = 4;
   localparam int PRIO_W      = 4;
   localparam int THR_W       = 7;
   localparam int LIMIT_W     = 23;
   localparam int CAP_W       = 7;
   localparam int QUOT_W      = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 23;

   localparam int THREAD_COUNT_DEF = 64;

   // Actions
   localparam logic [ACTION_W-1:0] ACT_RUN   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_WAKE  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd3;

   // Thread classes (anything else behaves as idle)
   localparam logic [CLASS_W-1:0] CLS_REALTIME  = 2'd0;
   localparam logic [CLASS_W-1:0] CLS_TIMESHARE = 2'd1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EPOCH_LIMIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOST_CAP   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE_SHORT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE_LONG  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE_IDLE  = 3'd5;

   // Register reset values
   localparam logic [THR_W-1:0]   THRESHOLD_RST   = 7'd30;
   localparam logic [LIMIT_W-1:0] EPOCH_LIMIT_RST = 23'd1000;
   localparam logic [CAP_W-1:0]   BOOST_CAP_RST   = 7'd20;
   localparam logic [SLICE_W-1:0] SLICE_SHORT_RST = 4'd4;
   localparam logic [SLICE_W-1:0] SLICE_LONG_RST  = 4'd8;
   localparam logic [SLICE_W-1:0] SLICE_IDLE_RST  = 4'd10;

   // Score arithmetic
   localparam logic signed [SCORE_W-1:0] SCORE_MAX   = 9'sd127;
   localparam logic signed [SCORE_W-1:0] SCORE_FLOOR = -9'sd128;
   localparam logic signed [SCORE_W-1:0] DECAY_STEP  = 9'sd2;

   // x/5 = (x*205)>>10 for x < 1024; x/20 = (x*205)>>12 for x < 1024
   localparam logic [7:0] RECIP_205   = 8'd205;
   localparam int         DIV5_SHIFT  = 10;
   localparam int         DIV20_SHIFT = 12;
   localparam logic [3:0] BOOST_DEN   = 4'd10;

   typedef struct packed {
      logic [CNT_W-1:0]          run_count;
      logic [CNT_W-1:0]          sleep_count;
      logic signed [SCORE_W-1:0] score;
      logic [SLICE_W-1:0]        slice;
   } entry_type;

   typedef struct packed {
      logic [THR_W-1:0]   threshold;
      logic [LIMIT_W-1:0] epoch_limit;
      logic [CAP_W-1:0]   boost_cap;
      logic [SLICE_W-1:0] slice_short;
      logic [SLICE_W-1:0] slice_long;
      logic [SLICE_W-1:0] slice_idle;
   } cfg_type;

endpackage

`default_nettype wire

FILE: hw/rtl/tis_table.sv
// Thread entry memory: one write port, one registered read port.
`default_nettype none

module tis_table import tis_pkg::*; #(
   parameter int THREAD_COUNT = THREAD_COUNT_DEF,
   parameter int ADDR_W       = 6
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire entry_type         wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output entry_type              rd_data
);

   entry_type mem [THREAD_COUNT];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/tis_divider.sv
// Restoring divider for the score ratio, one quotient bit per cycle.
`default_nettype none

module tis_divider import tis_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [CNT_W-1:0]   dividend,
   input  wire logic [TOTAL_W-1:0] divisor,
   output logic                    done,
   output logic [QUOT_W-1:0]       quotient
);

   localparam int REM_W = TOTAL_W + 1;
   localparam int CNT_BITS = $clog2(QUOT_W);

   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [TOTAL_W-1:0]  div_ff;
   logic [QUOT_W-1:0]   quot_ff;
   logic [CNT_BITS-1:0] step_ff;
   logic                first_ff;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [REM_W-1:0]    trial;
   logic                fits;

   // The dividend never exceeds the divisor, so the remainder stays below it
   assign trial  = first_ff ? rem_ff : {rem_ff[REM_W-2:0], 1'b0};
   assign fits   = trial >= {1'b0, div_ff};
   assign rem_in = fits ? trial - {1'b0, div_ff} : trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
      end else if (busy_ff && step_ff == CNT_BITS'(QUOT_W - 1)) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff   <= REM_W'(dividend);
         div_ff   <= divisor;
         quot_ff  <= '0;
         step_ff  <= '0;
         first_ff <= 1'b1;
      end else if (busy_ff) begin
         rem_ff   <= rem_in;
         quot_ff  <= {quot_ff[QUOT_W-2:0], fits};
         step_ff  <= step_ff + 1'b1;
         first_ff <= 1'b0;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

`ifndef NO_ASSERTIONS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/tis_update.sv
// Next entry value for one event: counters, score and slice.
`default_nettype none

module tis_update import tis_pkg::*; (
   input  wire entry_type              cur_entry,
   input  wire logic [ACTION_W-1:0]    action,
   input  wire logic [CLASS_W-1:0]     thread_class,
   input  wire logic [SLEPT_W-1:0]     slept_ticks,
   input  wire cfg_type                cfg,
   input  wire logic [TOTAL_W-1:0]     total,
   input  wire logic                   total_neg,
   input  wire logic [QUOT_W-1:0]      quotient,
   output entry_type                   nxt_entry
);

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   logic                      is_ts;
   logic signed [SCORE_W-1:0] thr_s;
   logic signed [SCORE_W-1:0] run_score;
   logic [CNT_W:0]            run_inc;
   logic [CNT_W:0]            sleep_sum;
   logic [SLEPT_W+1:0]        slept_x4;
   logic [10:0]               cap_lim;
   logic [17:0]               small_prod;
   logic [CAP_W-1:0]          boost;
   logic signed [SCORE_W:0]   wake_sum;
   logic signed [SCORE_W-1:0] wake_score;
   logic [SLICE_W:0]          slice_sum;
   logic [SLICE_W-1:0]        ts_slice;

   assign is_ts = thread_class == CLS_TIMESHARE;
   assign thr_s = $signed({2'b00, cfg.threshold});

   // Ratio magnitude is at most 128; only the positive side needs clamping
   always_comb begin
      if (total == '0) begin
         run_score = '0;
      end else if (total_neg) begin
         run_score = -$signed({1'b0, quotient});
      end else if (quotient[QUOT_W-1]) begin
         run_score = SCORE_MAX;
      end else begin
         run_score = $signed({1'b0, quotient});
      end
   end

   assign run_inc   = {1'b0, cur_entry.run_count} + (CNT_W+1)'(1);
   assign sleep_sum = {1'b0, cur_entry.sleep_count} + (CNT_W+1)'(slept_ticks);

   // Boost = min(slept*4/10, cap). Past the cap only the compare matters,
   // below it slept < 320 and slept*2/5 comes from a reciprocal.
   assign slept_x4   = {slept_ticks, 2'b00};
   assign cap_lim    = (11'(cfg.boost_cap) + 11'd1) * 11'(BOOST_DEN);
   assign small_prod = 18'({slept_ticks[8:0], 1'b0}) * 18'(RECIP_205);
   assign boost      = (slept_x4 >= (SLEPT_W+2)'(cap_lim)) ? cfg.boost_cap
                                                             : small_prod[DIV5_SHIFT +: CAP_W];

   assign wake_sum   = {cur_entry.score[SCORE_W-1], cur_entry.score}
                     + $signed({3'b000, boost});
   assign wake_score = (wake_sum > 10'sd127) ? SCORE_MAX : wake_sum[SCORE_W-1:0];

   assign slice_sum = {1'b0, cfg.slice_short} + {1'b0, cfg.slice_long};

   always_comb begin
      if (wake_score > thr_s) begin
         ts_slice = cfg.slice_short;
      end else if (wake_score < -thr_s) begin
         ts_slice = cfg.slice_long;
      end else begin
         ts_slice = slice_sum[SLICE_W:1];
      end
   end

   always_comb begin
      nxt_entry = cur_entry;
      case (action)
         ACT_RUN: begin
            if (is_ts) begin
               nxt_entry.score = run_score;
               if (total > TOTAL_W'(cfg.epoch_limit)) begin
                  nxt_entry.run_count   = cur_entry.run_count >> 1;
                  nxt_entry.sleep_count = cur_entry.sleep_count >> 1;
               end
            end
         end
         ACT_TICK: begin
            nxt_entry.run_count = run_inc[CNT_W] ? CNT_MAX : run_inc[CNT_W-1:0];
            if (cur_entry.slice != '0) begin
               nxt_entry.slice = cur_entry.slice - 1'b1;
            end
            if (is_ts && cur_entry.score > SCORE_FLOOR) begin
               nxt_entry.score = cur_entry.score - DECAY_STEP;
            end
         end
         ACT_WAKE: begin
            nxt_entry.sleep_count = sleep_sum[CNT_W] ? CNT_MAX : sleep_sum[CNT_W-1:0];
            if (thread_class == CLS_REALTIME) begin
               nxt_entry.slice = cfg.slice_short;
            end else if (is_ts) begin
               nxt_entry.score = wake_score;
               nxt_entry.slice = ts_slice;
            end else begin
               nxt_entry.slice = cfg.slice_idle;
            end
         end
         ACT_CLEAR: begin
            nxt_entry = '0;
         end
         default: begin
            nxt_entry = cur_entry;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hw/rtl/thread_interactivity_scorer.sv
// Top level of the thread interactivity scorer: control, registers and result stage.
//
// Usage:
//   req_*  : one event beat (action, thread_index, thread_class, slept_ticks),
//            taken when req_valid is high and req_stall is low.
//   rsp_*  : one result beat per event (score, slice_left, is_interactive,
//            priority_adjust), taken when rsp_valid is high and rsp_stall low.
//   csr_*  : register writes, index and data, taken when csr_valid is high;
//            csr_ready is always high. Write only while no event is in flight.
// Flow: an accepted in-table event passes the read, update and result
//   states; a timeshare run with a nonzero counter sum also passes the
//   divide state, where the divider forms the score ratio. One event is in
//   flight at a time, so a new beat is taken only once the previous one has
//   left the result state, as the entry memory's read, modify and write-back need.
// Reset: synchronous. Afterwards the block sweeps the entry memory to zero,
//   one entry per cycle, with req_stall high.
// Receiver stall: a finished result waits in the output register; the next
//   event is taken and worked on, and holds in its result state until the
//   output register frees up.
`default_nettype none

module thread_interactivity_scorer import tis_pkg::*; #(
   parameter int THREAD_COUNT = THREAD_COUNT_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // event channel
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [ACTION_W-1:0]       req_action,
   input  wire logic [IDX_W-1:0]          req_thread_index,
   input  wire logic [CLASS_W-1:0]        req_thread_class,
   input  wire logic [SLEPT_W-1:0]        req_slept_ticks,
   // result channel
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [SCORE_W-1:0]      rsp_score,
   output logic [SLICE_W-1:0]             rsp_slice_left,
   output logic                           rsp_is_interactive,
   output logic signed [PRIO_W-1:0]       rsp_priority_adjust,
   // register write channel
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_IDX_W-1:0]      csr_index,
   input  wire logic [CSR_DATA_W-1:0]     csr_data
);

   localparam int ADDR_W = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_UPDATE = 3'd4;
   localparam logic [2:0] ST_RESULT = 3'd5;

   logic [2:0]                state_ff, state_in;
   logic [ADDR_W-1:0]         clear_addr_ff;
   cfg_type                   cfg_ff;

   // event held for the duration of its work
   logic [ACTION_W-1:0]       act_ff;
   logic [IDX_W-1:0]          idx_ff;
   logic [CLASS_W-1:0]        cls_ff;
   logic [SLEPT_W-1:0]        slept_ff;
   logic                      idx_ok_ff;
   logic [TOTAL_W-1:0]        total_ff;
   logic                      neg_ff;
   logic signed [SCORE_W-1:0] score_ff;
   logic [SLICE_W-1:0]        slice_ff;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SCORE_W-1:0] rsp_score_ff;
   logic [SLICE_W-1:0]        rsp_slice_ff;
   logic                      rsp_inter_ff;
   logic signed [PRIO_W-1:0]  rsp_prio_ff;

   logic                      req_accept;
   logic                      req_idx_ok;
   logic                      rsp_load;

   entry_type                 tbl_rd_data;
   entry_type                 tbl_wr_data;
   entry_type                 upd_entry;
   logic                      tbl_wr_en;
   logic [ADDR_W-1:0]         tbl_wr_addr;

   logic [TOTAL_W-1:0]        total_w;
   logic                      neg_w;
   logic [CNT_W-1:0]          mag_w;
   logic                      div_start;
   logic                      div_done;
   logic [QUOT_W-1:0]         div_quot;

   // output stage arithmetic
   logic signed [SCORE_W-1:0] thr_s;
   logic signed [SCORE_W:0]   sc10;
   logic signed [SCORE_W:0]   thr10;
   logic                      above;
   logic                      below;
   logic signed [SCORE_W:0]   excess10;
   logic [15:0]               prio_prod;
   logic [PRIO_W-1:0]         prio_mag;
   logic signed [PRIO_W-1:0]  prio_w;

   assign req_stall  = state_ff != ST_IDLE;
   assign req_accept = req_valid && !req_stall;
   assign req_idx_ok = 32'(req_thread_index) < 32'(THREAD_COUNT);
   assign csr_ready  = 1'b1;

   // ---------------------------------------------------------------
   // Register file; writes past the list drop
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold   <= THRESHOLD_RST;
         cfg_ff.epoch_limit <= EPOCH_LIMIT_RST;
         cfg_ff.boost_cap   <= BOOST_CAP_RST;
         cfg_ff.slice_short <= SLICE_SHORT_RST;
         cfg_ff.slice_long  <= SLICE_LONG_RST;
         cfg_ff.slice_idle  <= SLICE_IDLE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_THRESHOLD:   cfg_ff.threshold   <= csr_data[THR_W-1:0];
            CSR_EPOCH_LIMIT: cfg_ff.epoch_limit <= csr_data[LIMIT_W-1:0];
            CSR_BOOST_CAP:   cfg_ff.boost_cap   <= csr_data[CAP_W-1:0];
            CSR_SLICE_SHORT: cfg_ff.slice_short <= csr_data[SLICE_W-1:0];
            CSR_SLICE_LONG:  cfg_ff.slice_long  <= csr_data[SLICE_W-1:0];
            CSR_SLICE_IDLE:  cfg_ff.slice_idle  <= csr_data[SLICE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Entry memory, divider and update logic
   // ---------------------------------------------------------------
   // Only the update state writes an event's entry; the sweep writes zeros
   assign tbl_wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_UPDATE);
   assign tbl_wr_addr = (state_ff == ST_CLEAR) ? clear_addr_ff : ADDR_W'(idx_ff);
   assign tbl_wr_data = (state_ff == ST_CLEAR) ? '0 : upd_entry;

   tis_table #(
      .THREAD_COUNT (THREAD_COUNT),
      .ADDR_W       (ADDR_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (req_accept),
      .rd_addr (ADDR_W'(req_thread_index)),
      .rd_data (tbl_rd_data)
   );

   // Counter sum and |sleep - run| straight off the read port
   assign total_w = {1'b0, tbl_rd_data.run_count} + {1'b0, tbl_rd_data.sleep_count};
   assign neg_w   = tbl_rd_data.sleep_count < tbl_rd_data.run_count;
   assign mag_w   = neg_w ? tbl_rd_data.run_count - tbl_rd_data.sleep_count
                          : tbl_rd_data.sleep_count - tbl_rd_data.run_count;

   assign div_start = (state_ff == ST_READ) && (act_ff == ACT_RUN)
                   && (cls_ff == CLS_TIMESHARE) && (total_w != '0);

   tis_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_w),
      .divisor  (total_w),
      .done     (div_done),
      .quotient (div_quot)
   );

   tis_update u_update (
      .cur_entry    (tbl_rd_data),
      .action       (act_ff),
      .thread_class (cls_ff),
      .slept_ticks  (slept_ff),
      .cfg          (cfg_ff),
      .total        (total_ff),
      .total_neg    (neg_ff),
      .quotient     (div_quot),
      .nxt_entry    (upd_entry)
   );

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   assign rsp_load = (state_ff == ST_RESULT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_addr_ff == ADDR_W'(THREAD_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = req_idx_ok ? ST_READ : ST_RESULT;
            end
         end
         ST_READ: begin
            state_in = div_start ? ST_DIV : ST_UPDATE;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clear_addr_ff <= clear_addr_ff + 1'b1;
         end
      end
   end

   // Hold the event; counter sum and sign for update, score and slice for result
   always_ff @(posedge clock) begin
      if (req_accept) begin
         act_ff    <= req_action;
         idx_ff    <= req_thread_index;
         cls_ff    <= req_thread_class;
         slept_ff  <= req_slept_ticks;
         idx_ok_ff <= req_idx_ok;
      end
      if (state_ff == ST_READ) begin
         total_ff <= total_w;
         neg_ff   <= neg_w;
      end
      if (state_ff == ST_UPDATE) begin
         score_ff <= upd_entry.score;
         slice_ff <= upd_entry.slice;
      end
   end

   // ---------------------------------------------------------------
   // Result stage: interactive flag and priority adjustment
   // ---------------------------------------------------------------
   assign thr_s = $signed({2'b00, cfg_ff.threshold});
   assign sc10  = {score_ff[SCORE_W-1], score_ff};
   assign thr10 = $signed({3'b000, cfg_ff.threshold});
   assign above = score_ff > thr_s;
   assign below = score_ff < -thr_s;

   // Distance past the threshold is at most 129; divide by 20 via reciprocal
   always_comb begin
      if (above) begin
         excess10 = sc10 - thr10;
      end else if (below) begin
         excess10 = -sc10 - thr10;
      end else begin
         excess10 = '0;
      end
   end

   assign prio_prod = 16'(excess10[7:0]) * 16'(RECIP_205);
   assign prio_mag  = prio_prod[DIV20_SHIFT +: PRIO_W];

   always_comb begin
      if (cls_ff != CLS_TIMESHARE) begin
         prio_w = '0;
      end else if (above) begin
         prio_w = -$signed(prio_mag);
      end else begin
         prio_w = $signed(prio_mag);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Out-of-table events answer with all zeros
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (idx_ok_ff) begin
            rsp_score_ff <= score_ff;
            rsp_slice_ff <= slice_ff;
            rsp_inter_ff <= above;
            rsp_prio_ff  <= prio_w;
         end else begin
            rsp_score_ff <= '0;
            rsp_slice_ff <= '0;
            rsp_inter_ff <= 1'b0;
            rsp_prio_ff  <= '0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_score           = rsp_score_ff;
   assign rsp_slice_left      = rsp_slice_ff;
   assign rsp_is_interactive  = rsp_inter_ff;
   assign rsp_priority_adjust = rsp_prio_ff;

`ifndef NO_ASSERTIONS
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   a_bad_index_skips: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_idx_ok) |=> (state_ff == ST_RESULT))
      else $error("out-of-table event entered the memory path");

   a_write_ok: assert property (@(posedge clock) disable iff (reset)
      tbl_wr_en |-> ((state_ff == ST_CLEAR) || idx_ok_ff))
      else $error("entry write for an out-of-table index");

   a_prio_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_priority_adjust >= -4'sd6) && (rsp_priority_adjust <= 4'sd6)))
      else $error("priority adjustment out of range");
`endif

endmodule

`default_nettype wire
